[sv/nhsg_pkg.sv]
// Package for the neo-Hookean stretch gradient and Hessian unit.
// Holds the word types, pipeline depths and the log table functions.
// Depends on nothing.
`default_nettype none
package nhsg_pkg;

	localparam int LOG_LAT = 50;
	localparam int LOG_STEPS = 48;
	localparam int DIV_LAT = 104;

	typedef logic [LOG_STEPS-1:0][63:0] ln_tab_t;

	typedef struct packed {
		logic [31:0] stretch_1;
		logic [31:0] stretch_2;
		logic [31:0] stretch_3;
	} in_word_t;

	typedef struct packed {
		logic signed [63:0] grad_1;
		logic signed [63:0] grad_2;
		logic signed [63:0] grad_3;
		logic signed [63:0] hess_11;
		logic signed [63:0] hess_22;
		logic signed [63:0] hess_33;
		logic signed [63:0] hess_12;
		logic signed [63:0] hess_13;
		logic signed [63:0] hess_23;
		logic domain_error;
		logic saturated;
	} out_word_t;

	typedef struct packed {
		logic dom;
		logic [2:0][31:0] s;
	} info_t;

	typedef struct packed {
		logic valid;
		info_t data;
	} feed_t;

	typedef struct packed {
		logic [31:0] mu;
		logic [31:0] lam;
	} cfg_t;

	function automatic logic [63:0] nhsg_udiv(input logic [63:0] n, input logic [63:0] d);
		logic [64:0] r;
		logic [63:0] q;
		r = '0;
		q = '0;
		for (int b = 63; b >= 0; b--) begin
			r = {r[63:0], n[b]};
			q = {q[62:0], 1'b0};
			if (r >= {1'b0, d}) begin
				r = r - {1'b0, d};
				q[0] = 1'b1;
			end
		end
		return q;
	endfunction

	function automatic ln_tab_t nhsg_ln_table();
		ln_tab_t tab;
		logic [63:0] acc;
		logic [63:0] term;
		tab = '0;
		for (int k = 1; k <= LOG_STEPS; k++) begin
			acc = '0;
			for (int n = 1; n <= 62; n++) begin
				if (k * n <= 62) begin
					term = nhsg_udiv(64'd1 << (62 - k * n), 64'(n));
					if (n % 2 == 1) begin
						acc = acc + term;
					end else begin
						acc = acc - term;
					end
				end
			end
			tab[k-1] = (acc + 64'd32) >> 6;
		end
		return tab;
	endfunction

	function automatic logic [63:0] nhsg_ln2();
		ln_tab_t tab;
		logic [63:0] m;
		logic [63:0] t;
		logic [63:0] acc;
		tab = nhsg_ln_table();
		m = 64'd1 << 62;
		acc = '0;
		for (int k = 1; k <= LOG_STEPS; k++) begin
			t = m + (m >> k);
			if (!t[63]) begin
				m = t;
				acc = acc + tab[k-1];
			end
		end
		return acc;
	endfunction

endpackage
`default_nettype wire

[sv/nhsg_front.sv]
// Front end: masks and classifies incoming stretch words and queues them.
// Uses nhsg_pkg; feeds nhsg_back.
`default_nettype none
module nhsg_front import nhsg_pkg::*; #(
	parameter int STRETCH_WIDTH = 32
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     push,
	input  wire in_word_t item,
	output logic          full,
	input  wire logic     take,
	output feed_t         feed
);

	localparam int SW = (STRETCH_WIDTH < 32) ? STRETCH_WIDTH : 32;
	localparam logic [31:0] MASK = 32'((64'd1 << SW) - 64'd1);
	localparam int DEPTH = 4;

	info_t       q_q [DEPTH];
	logic [1:0]  wr_q;
	logic [1:0]  rd_q;
	logic [2:0]  cnt_q;
	info_t       cls;
	logic        do_push;
	logic        do_pop;

	always_comb begin
		cls.s[0] = item.stretch_1 & MASK;
		cls.s[1] = item.stretch_2 & MASK;
		cls.s[2] = item.stretch_3 & MASK;
		cls.dom = (cls.s[0] == '0) || (cls.s[1] == '0) || (cls.s[2] == '0);
	end

	assign full = (cnt_q == 3'(DEPTH));
	assign do_push = push && !full;
	assign do_pop = take && (cnt_q != '0);
	assign feed.valid = (cnt_q != '0);
	assign feed.data = q_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= wr_q + 2'd1;
			end
			if (do_pop) begin
				rd_q <= rd_q + 2'd1;
			end
			cnt_q <= cnt_q + 3'(do_push) - 3'(do_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			q_q[wr_q] <= cls;
		end
	end

endmodule
`default_nettype wire

[sv/nhsg_log.sv]
// Pipelined natural log of a Q8.24 stretch, result in Q.56, one step per stage.
// Uses nhsg_pkg for the factor table and depth.
`default_nettype none
module nhsg_log import nhsg_pkg::*; (
	input  wire logic        clk,
	input  wire logic        en,
	input  wire logic [31:0] x,
	output logic [63:0]      ln
);

	localparam ln_tab_t LN_TAB = nhsg_ln_table();
	localparam logic [63:0] LN2 = nhsg_ln2();

	logic [63:0] m_s   [1:LOG_STEPS+1];
	logic [63:0] acc_s [1:LOG_STEPS+1];
	logic [4:0]  p_s   [1:LOG_STEPS+1];
	logic [63:0] ln_s;
	logic [4:0]  p_w;

	always_comb begin
		p_w = '0;
		for (int b = 0; b < 32; b++) begin
			if (x[b]) begin
				p_w = 5'(b);
			end
		end
	end

	always_ff @(posedge clk) begin
		logic [63:0] t;
		logic [7:0] pd;
		if (en) begin
			m_s[1] <= {32'b0, x} << (6'd62 - {1'b0, p_w});
			acc_s[1] <= '0;
			p_s[1] <= p_w;
			for (int j = 2; j <= LOG_STEPS + 1; j++) begin
				t = m_s[j-1] + (m_s[j-1] >> (j - 1));
				p_s[j] <= p_s[j-1];
				if (!t[63]) begin
					m_s[j] <= t;
					acc_s[j] <= acc_s[j-1] + LN_TAB[j-2];
				end else begin
					m_s[j] <= m_s[j-1];
					acc_s[j] <= acc_s[j-1];
				end
			end
			pd = {3'b0, p_s[LOG_STEPS+1]} - 8'd23;
			ln_s <= 64'($signed({{56{pd[7]}}, pd}) * $signed(LN2)) - acc_s[LOG_STEPS+1];
		end
	end

	assign ln = ln_s;

endmodule
`default_nettype wire

[sv/nhsg_div.sv]
// Pipelined restoring divider, one quotient bit per stage after the pad stages,
// with a tag that rides along. Standalone; used by nhsg_back.
`default_nettype none
module nhsg_div #(
	parameter int NW = 80,
	parameter int DW = 32,
	parameter int LAT = 104,
	parameter int TW = 1
) (
	input  wire logic          clk,
	input  wire logic          en,
	input  wire logic [NW-1:0] num,
	input  wire logic [DW-1:0] den,
	input  wire logic [TW-1:0] tag,
	output logic [NW-1:0]      quo,
	output logic [TW-1:0]      tag_o
);

	logic [DW-1:0] rem_s [1:LAT];
	logic [NW-1:0] nq_s  [1:LAT];
	logic [DW-1:0] den_s [1:LAT];
	logic [TW-1:0] tag_s [1:LAT];

	for (genvar k = 0; k < LAT; k++) begin : g_stage
		logic [DW-1:0] r_in;
		logic [NW-1:0] nq_in;
		logic [DW-1:0] d_in;
		logic [TW-1:0] t_in;
		if (k == 0) begin : g_first
			assign r_in = '0;
			assign nq_in = num;
			assign d_in = den;
			assign t_in = tag;
		end else begin : g_next
			assign r_in = rem_s[k];
			assign nq_in = nq_s[k];
			assign d_in = den_s[k];
			assign t_in = tag_s[k];
		end
		if (k < LAT - NW) begin : g_pad
			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[k+1] <= r_in;
					nq_s[k+1] <= nq_in;
					den_s[k+1] <= d_in;
					tag_s[k+1] <= t_in;
				end
			end
		end else begin : g_bit
			logic [DW:0] trial;
			logic [DW:0] diff;
			assign trial = {r_in, nq_in[NW-1]};
			assign diff = trial - {1'b0, d_in};
			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[k+1] <= diff[DW] ? trial[DW-1:0] : diff[DW-1:0];
					nq_s[k+1] <= {nq_in[NW-2:0], !diff[DW]};
					den_s[k+1] <= d_in;
					tag_s[k+1] <= t_in;
				end
			end
		end
	end

	assign quo = nq_s[LAT];
	assign tag_o = tag_s[LAT];

endmodule
`default_nettype wire

[sv/nhsg_back.sv]
// Back end: logs, moduli products, quotients, clipping and the result buffer.
// Uses nhsg_pkg, nhsg_log and nhsg_div.
`default_nettype none
module nhsg_back import nhsg_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire feed_t feed,
	output logic       take,
	input  wire cfg_t  cfg,
	input  wire logic  pop,
	output logic       empty,
	output out_word_t  result
);

	localparam int ST_SUM = LOG_LAT + 1;
	localparam int ST_RND = ST_SUM + 1;
	localparam int ST_MUL = ST_RND + 1;
	localparam int ST_GH = ST_MUL + 1;
	localparam int ST_DIN = ST_GH + 1;
	localparam int ST_DOUT = ST_DIN + DIV_LAT;
	localparam int ST_E1 = ST_DOUT + 1;

	logic              en;
	logic [ST_E1:0]    vld_s;
	info_t             dl_s [0:ST_E1];
	logic [63:0]       ln_w [3];
	logic [63:0]       lsum_s;
	logic [31:0]       l24mag_s;
	logic              l24neg_s;
	logic [63:0]       prod_s;
	logic              pneg_s;
	logic [65:0]       g_s;
	logic [65:0]       h_s;
	logic [63:0]       gmag_s;
	logic              gneg_s;
	logic [63:0]       hmag_s;
	logic              hneg_s;
	logic [63:0]       ss_s [3];
	logic [63:0]       sab_s [3];
	logic [79:0]       qg [3];
	logic              tg [3];
	logic [103:0]      qh [3];
	logic              th [3];
	logic [95:0]       qo [3];
	logic [55:0]       a_s [3];
	logic [80:0]       b_s [3];
	logic [104:0]      c_s [3];
	logic [95:0]       o_s [3];
	out_word_t         res;
	out_word_t         ob_q [2];
	logic              wr_q;
	logic              rd_q;
	logic [1:0]        cnt_q;
	logic              do_wr;
	logic              do_pop;

	function automatic logic [64:0] clip(input logic [127:0] v);
		if (v[127:63] == '0 || v[127:63] == '1) begin
			return {1'b0, v[63:0]};
		end else if (v[127]) begin
			return {2'b11, 63'b0};
		end else begin
			return {2'b10, {63{1'b1}}};
		end
	endfunction

	assign en = (cnt_q != 2'd2);
	assign take = en && feed.valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[ST_E1-1:0], take};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dl_s[0] <= feed.data;
			for (int k = 1; k <= ST_E1; k++) begin
				dl_s[k] <= dl_s[k-1];
			end
		end
	end

	for (genvar i = 0; i < 3; i++) begin : g_log
		nhsg_log u_log (
			.clk (clk),
			.en  (en),
			.x   (dl_s[0].s[i]),
			.ln  (ln_w[i])
		);
	end

	always_ff @(posedge clk) begin
		logic [63:0] lmag;
		logic [63:0] rnd;
		logic [65:0] pv;
		if (en) begin
			lsum_s <= ln_w[0] + ln_w[1] + ln_w[2];
			lmag = lsum_s[63] ? (~lsum_s + 64'd1) : lsum_s;
			rnd = lmag + 64'h8000_0000;
			l24mag_s <= rnd[63:32];
			l24neg_s <= lsum_s[63];
			prod_s <= 64'(cfg.lam) * 64'(l24mag_s);
			pneg_s <= l24neg_s;
			pv = pneg_s ? (~{2'b0, prod_s} + 66'd1) : {2'b0, prod_s};
			g_s <= pv - {10'b0, cfg.mu, 24'b0};
			h_s <= {9'b0, {1'b0, cfg.mu} + {1'b0, cfg.lam}, 24'b0} - pv;
			gneg_s <= g_s[65];
			gmag_s <= g_s[65] ? 64'(~g_s + 66'd1) : g_s[63:0];
			hneg_s <= h_s[65];
			hmag_s <= h_s[65] ? 64'(~h_s + 66'd1) : h_s[63:0];
			for (int i = 0; i < 3; i++) begin
				ss_s[i] <= 64'(dl_s[ST_GH].s[i]) * 64'(dl_s[ST_GH].s[i]);
			end
			sab_s[0] <= 64'(dl_s[ST_GH].s[0]) * 64'(dl_s[ST_GH].s[1]);
			sab_s[1] <= 64'(dl_s[ST_GH].s[0]) * 64'(dl_s[ST_GH].s[2]);
			sab_s[2] <= 64'(dl_s[ST_GH].s[1]) * 64'(dl_s[ST_GH].s[2]);
		end
	end

	for (genvar i = 0; i < 3; i++) begin : g_div
		nhsg_div #(.NW(80), .DW(32), .LAT(DIV_LAT), .TW(1)) u_grad (
			.clk   (clk),
			.en    (en),
			.num   ({gmag_s, 16'b0}),
			.den   (dl_s[ST_DIN].s[i]),
			.tag   (gneg_s),
			.quo   (qg[i]),
			.tag_o (tg[i])
		);
		nhsg_div #(.NW(104), .DW(64), .LAT(DIV_LAT), .TW(1)) u_hess (
			.clk   (clk),
			.en    (en),
			.num   ({hmag_s, 40'b0}),
			.den   (ss_s[i]),
			.tag   (hneg_s),
			.quo   (qh[i]),
			.tag_o (th[i])
		);
		nhsg_div #(.NW(96), .DW(64), .LAT(DIV_LAT), .TW(1)) u_off (
			.clk   (clk),
			.en    (en),
			.num   ({cfg.lam, 64'b0}),
			.den   (sab_s[i]),
			.tag   (1'b0),
			.quo   (qo[i]),
			.tag_o ()
		);
	end

	always_ff @(posedge clk) begin
		logic [63:0] ms;
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				ms = 64'(cfg.mu) * 64'(dl_s[ST_DOUT].s[i]);
				a_s[i] <= ms[63:8];
				b_s[i] <= tg[i] ? (~{1'b0, qg[i]} + 81'd1) : {1'b0, qg[i]};
				c_s[i] <= th[i] ? (~{1'b0, qh[i]} + 105'd1) : {1'b0, qh[i]};
				o_s[i] <= qo[i];
			end
		end
	end

	always_comb begin
		logic [64:0] cg [3];
		logic [64:0] ch [3];
		logic [64:0] co [3];
		for (int i = 0; i < 3; i++) begin
			cg[i] = clip({{47{b_s[i][80]}}, b_s[i]} + {72'b0, a_s[i]});
			ch[i] = clip({{23{c_s[i][104]}}, c_s[i]} + {80'b0, cfg.mu, 16'b0});
			co[i] = clip({32'b0, o_s[i]});
		end
		res.grad_1 = cg[0][63:0];
		res.grad_2 = cg[1][63:0];
		res.grad_3 = cg[2][63:0];
		res.hess_11 = ch[0][63:0];
		res.hess_22 = ch[1][63:0];
		res.hess_33 = ch[2][63:0];
		res.hess_12 = co[0][63:0];
		res.hess_13 = co[1][63:0];
		res.hess_23 = co[2][63:0];
		res.domain_error = 1'b0;
		res.saturated = cg[0][64] | cg[1][64] | cg[2][64] | ch[0][64] | ch[1][64]
			| ch[2][64] | co[0][64] | co[1][64] | co[2][64];
		if (dl_s[ST_E1].dom) begin
			res = '0;
			res.domain_error = 1'b1;
		end
	end

	assign do_wr = en && vld_s[ST_E1];
	assign do_pop = pop && (cnt_q != '0);
	assign empty = (cnt_q == '0);
	assign result = ob_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= 1'b0;
			rd_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (do_wr) begin
				wr_q <= !wr_q;
			end
			if (do_pop) begin
				rd_q <= !rd_q;
			end
			cnt_q <= cnt_q + 2'(do_wr) - 2'(do_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			ob_q[wr_q] <= res;
		end
	end

endmodule
`default_nettype wire

[sv/neohookean_stretch_gradient_hessian_unit.sv]
// Top level of the neo-Hookean stretch gradient and Hessian unit.
// Uses nhsg_pkg, nhsg_front and nhsg_back; holds the APB register file.
//
// Channel   Direction  Handshake                        Payload
// item      in         push, full                       in_word_t
// result    out        empty, pop                       out_word_t
// apb       in/out     psel, penable, pwrite, pready    paddr, pwdata, prdata
//
// One stretch word is taken per cycle unless the back pipeline is stalled;
// a result passes the 48-step log pipeline and the 104-stage dividers.
// Reset clears the queues and loads both moduli with 1.0; no clearing pass.
// A full result buffer stalls the whole back pipeline; the input queue then
// fills and raises full.
`default_nettype none
module neohookean_stretch_gradient_hessian_unit import nhsg_pkg::*; #(
	parameter int STRETCH_WIDTH = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	output logic             full,
	input  wire in_word_t    item,
	output logic             empty,
	input  wire logic        pop,
	output out_word_t        result,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	localparam logic REG_SHEAR = 1'b0;
	localparam logic REG_LAMBDA = 1'b1;

	cfg_t  cfg_q;
	feed_t feed;
	logic  take;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mu <= 32'd256;
			cfg_q.lam <= 32'd256;
		end else if (psel && penable && pwrite) begin
			case (paddr[2])
				REG_SHEAR: cfg_q.mu <= pwdata;
				REG_LAMBDA: cfg_q.lam <= pwdata;
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_SHEAR: prdata = cfg_q.mu;
			REG_LAMBDA: prdata = cfg_q.lam;
			default: prdata = '0;
		endcase
	end

	nhsg_front #(.STRETCH_WIDTH(STRETCH_WIDTH)) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.item   (item),
		.full   (full),
		.take   (take),
		.feed   (feed)
	);

	nhsg_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.feed   (feed),
		.take   (take),
		.cfg    (cfg_q),
		.pop    (pop),
		.empty  (empty),
		.result (result)
	);

	a_take_valid: assert property (@(posedge clk) disable iff (!arst_n)
		take |-> feed.valid) else $error("back end took from an empty queue");

	a_full_holds: assert property (@(posedge clk) disable iff (!arst_n)
		full && !take |=> full) else $error("input queue drained without a take");

	a_dom_zero: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && result.domain_error |-> !result.saturated && result.grad_1 == '0
		&& result.hess_11 == '0 && result.hess_12 == '0)
		else $error("domain error word carries nonzero data");

endmodule
`default_nettype wire

[verif/tb.sv]
// Self-checking testbench for neohookean_stretch_gradient_hessian_unit.
// Predicts each result word from the stretch words and the moduli and checks it.
// Depends on nhsg_pkg and the unit's RTL.
`default_nettype none
module tb import nhsg_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 2000000;
	localparam int DRAIN_CYCLES = 200;
	localparam logic [2:0] ADDR_MU = 3'd0;
	localparam logic [2:0] ADDR_LAMBDA = 3'd4;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic full;
	in_word_t item = '0;
	logic empty;
	logic pop = 1'b0;
	out_word_t result;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [2:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	neohookean_stretch_gradient_hessian_unit u_dut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .item(item),
		.empty(empty), .pop(pop), .result(result), .psel(psel), .penable(penable),
		.pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	in_word_t stretch_q[$];
	out_word_t derivs_q[$];
	logic [31:0] mu_model = 32'd256;
	logic [31:0] lambda_model = 32'd256;
	logic [63:0] ln_step_tab[1:48];
	logic [63:0] ln_two;
	bit bursts_on = 1'b1;
	int send_gap = 0;
	int recv_gap = 0;
	int mismatches = 0;
	int cycles = 0;

	initial begin
		forever #1 clk = ~clk;
	end

	function automatic logic [63:0] ln_step(int k);
		logic [63:0] s;
		s = '0;
		for (int n = 1; k * n <= 62; n++) begin
			if (n % 2 == 1) s = s + (64'd1 << (62 - k * n)) / 64'(n);
			else s = s - (64'd1 << (62 - k * n)) / 64'(n);
		end
		return (s + 64'd32) >> 6;
	endfunction

	function automatic logic [63:0] ln_to_two(logic [63:0] m);
		logic [63:0] acc;
		logic [63:0] t;
		acc = '0;
		for (int k = 1; k <= 48; k++) begin
			t = m + (m >> k);
			if (!t[63]) begin
				m = t;
				acc = acc + ln_step_tab[k];
			end
		end
		return acc;
	endfunction

	function automatic longint ln_stretch(logic [31:0] x);
		int p;
		p = 31;
		while (p > 0 && !x[p]) p--;
		return longint'(p - 24) * longint'(ln_two) + longint'(ln_two)
			- longint'(ln_to_two({32'b0, x} << (62 - p)));
	endfunction

	function automatic logic [63:0] clip(logic signed [127:0] v, inout logic sat);
		if (v > 128'sh7FFFFFFFFFFFFFFF) begin
			sat = 1'b1;
			return 64'h7FFFFFFFFFFFFFFF;
		end
		if (v < -128'sh8000000000000000) begin
			sat = 1'b1;
			return 64'h8000000000000000;
		end
		return v[63:0];
	endfunction

	function automatic out_word_t stretch_derivs(in_word_t w);
		out_word_t r;
		logic [31:0] s[3];
		logic signed [127:0] sw[3];
		logic signed [127:0] muw, lamw, lw, g, h, a, b, c;
		longint lsum, l24;
		logic sat;
		r = '0;
		sat = 1'b0;
		s[0] = w.stretch_1;
		s[1] = w.stretch_2;
		s[2] = w.stretch_3;
		if (s[0] == 0 || s[1] == 0 || s[2] == 0) begin
			r.domain_error = 1'b1;
			return r;
		end
		lsum = 0;
		for (int i = 0; i < 3; i++) begin
			lsum += ln_stretch(s[i]);
			sw[i] = {96'b0, s[i]};
		end
		if (lsum >= 0) l24 = (lsum + (64'sd1 <<< 31)) >>> 32;
		else l24 = -(((-lsum) + (64'sd1 <<< 31)) >>> 32);
		muw = {96'b0, mu_model};
		lamw = {96'b0, lambda_model};
		lw = l24;
		g = lamw * lw - (muw <<< 24);
		h = (muw <<< 24) + (lamw <<< 24) - lamw * lw;
		for (int i = 0; i < 3; i++) begin
			a = (muw * sw[i]) >>> 8;
			b = (g <<< 16) / sw[i];
			c = (h <<< 40) / (sw[i] * sw[i]);
			case (i)
				0: begin
					r.grad_1 = clip(a + b, sat);
					r.hess_11 = clip((muw <<< 16) + c, sat);
				end
				1: begin
					r.grad_2 = clip(a + b, sat);
					r.hess_22 = clip((muw <<< 16) + c, sat);
				end
				default: begin
					r.grad_3 = clip(a + b, sat);
					r.hess_33 = clip((muw <<< 16) + c, sat);
				end
			endcase
		end
		r.hess_12 = clip((lamw <<< 64) / (sw[0] * sw[1]), sat);
		r.hess_13 = clip((lamw <<< 64) / (sw[0] * sw[2]), sat);
		r.hess_23 = clip((lamw <<< 64) / (sw[1] * sw[2]), sat);
		r.saturated = sat;
		return r;
	endfunction

	function automatic logic [31:0] rand_stretch();
		case ($urandom_range(0, 9))
			0: return $urandom();
			1: return $urandom_range(1, 255);
			2: return 32'h0100_0000 + $urandom_range(0, 255) - 128;
			3: return ($urandom_range(0, 29) == 0) ? 32'd0 : $urandom();
			4: return 32'hFFFF_FF00 | $urandom_range(0, 255);
			default: return $urandom_range(32'h0040_0000, 32'h0400_0000);
		endcase
	endfunction

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && (!push || !full)) begin
			if (push) derivs_q.push_back(stretch_derivs(item));
			if (send_gap > 0) begin
				push <= 1'b0;
				send_gap <= send_gap - 1;
			end else if (stretch_q.size() > 0) begin
				item <= stretch_q.pop_front();
				push <= 1'b1;
				if (bursts_on && $urandom_range(0, 9) == 0) send_gap <= $urandom_range(1, 15);
			end else begin
				push <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		out_word_t want;
		if (arst_n) begin
			if (pop && !empty) begin
				if (derivs_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10) $display("unexpected word %h", result);
				end else begin
					want = derivs_q.pop_front();
					if (result !== want) begin
						mismatches++;
						if (mismatches <= 10)
							$display("word mismatch\n  expected %h\n  actual   %h", want, result);
					end
				end
			end
			if (recv_gap > 0) begin
				pop <= 1'b0;
				recv_gap <= recv_gap - 1;
			end else begin
				pop <= 1'b1;
				if (bursts_on && $urandom_range(0, 9) == 0) recv_gap <= $urandom_range(1, 15);
			end
		end
	end

	task automatic wait_idle();
		while (stretch_q.size() > 0 || push || derivs_q.size() > 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic reg_write(logic [2:0] addr, logic [31:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		if (addr == ADDR_MU) mu_model = value;
		else lambda_model = value;
	endtask

	task automatic set_moduli(logic [31:0] mu, logic [31:0] lam);
		wait_idle();
		reg_write(ADDR_MU, mu);
		reg_write(ADDR_LAMBDA, lam);
	endtask

	task automatic queue_word(logic [31:0] a, logic [31:0] b, logic [31:0] c);
		in_word_t w;
		w.stretch_1 = a;
		w.stretch_2 = b;
		w.stretch_3 = c;
		stretch_q.push_back(w);
	endtask

	task automatic queue_random(int n);
		repeat (n) queue_word(rand_stretch(), rand_stretch(), rand_stretch());
	endtask

	task automatic queue_directed();
		queue_word(32'h0100_0000, 32'h0100_0000, 32'h0100_0000);
		queue_word(32'd0, 32'h0100_0000, 32'h0100_0000);
		queue_word(32'h0100_0000, 32'd0, 32'h0100_0000);
		queue_word(32'h0100_0000, 32'h0100_0000, 32'd0);
		queue_word(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		queue_word(32'd1, 32'd1, 32'd1);
		queue_word(32'd1, 32'hFFFF_FFFF, 32'h0100_0000);
		queue_word(32'h8000_0000, 32'h0080_0000, 32'h0200_0000);
	endtask

	initial begin
		for (int k = 1; k <= 48; k++) ln_step_tab[k] = ln_step(k);
		ln_two = ln_to_two(64'd1 << 62);
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		queue_directed();
		set_moduli(32'd0, 32'd0);
		queue_directed();
		set_moduli(32'hFFFF_FFFF, 32'hFFFF_FFFF);
		queue_directed();
		set_moduli(32'd1, 32'hFFFF_FFFF);
		queue_random(150);
		set_moduli($urandom(), $urandom_range(0, 32'h0001_0000));
		queue_random(200);
		set_moduli($urandom_range(1, 32'h0000_4000), $urandom_range(1, 32'h0000_4000));
		queue_random(200);
		set_moduli(32'hFFFF_FFFF, 32'd0);
		bursts_on = 1'b0;
		queue_random(150);
		wait_idle();
		if (mismatches == 0) $display("end of test: clean");
		else $display("end of test: mismatches");
		$finish;
	end
endmodule
`default_nettype wire
